// ----- sv/sdspi_pkg.sv -----
// Shared types and constants for the SPI-mode SD card host sequencer.
package sdspi_pkg;

   typedef enum logic [1:0] {
      KIND_REQUEST = 2'd0,
      KIND_CARD    = 2'd1,
      KIND_WDATA   = 2'd2,
      KIND_TICK    = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      REQ_INIT  = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2,
      REQ_BAD   = 2'd3
   } request_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_ERROR    = 2'd1,
      ST_NOTREADY = 2'd2,
      ST_NOCARD   = 2'd3
   } status_type;

   typedef enum logic [13:0] {
      PH_IDLE    = 14'b00000000000001,
      PH_DUMMY   = 14'b00000000000010,
      PH_CWAIT   = 14'b00000000000100,
      PH_CFRAME  = 14'b00000000001000,
      PH_CRESP   = 14'b00000000010000,
      PH_SETTLE  = 14'b00000000100000,
      PH_R4      = 14'b00000001000000,
      PH_TOKEN   = 14'b00000010000000,
      PH_RDATA   = 14'b00000100000000,
      PH_WTOKEN  = 14'b00001000000000,
      PH_WWANT   = 14'b00010000000000,
      PH_WDATA   = 14'b00100000000000,
      PH_WBUSY   = 14'b01000000000000,
      PH_STATUS2 = 14'b10000000000000
   } phase_type;

   localparam logic [2:0] CSR_CMD_TIMEOUT  = 3'd0;
   localparam logic [2:0] CSR_OP_TIMEOUT   = 3'd1;
   localparam logic [2:0] CSR_WBUSY_TIMEOUT = 3'd2;
   localparam logic [2:0] CSR_POLL_LIMIT   = 3'd3;
   localparam logic [2:0] CSR_SETTLE       = 3'd4;

   localparam logic [5:0] CMD_GO_IDLE   = 6'd0;
   localparam logic [5:0] CMD_IF_COND   = 6'd8;
   localparam logic [5:0] CMD_STATUS    = 6'd13;
   localparam logic [5:0] CMD_READ      = 6'd17;
   localparam logic [5:0] CMD_WRITE     = 6'd24;
   localparam logic [5:0] CMD_APP_OP    = 6'd41;
   localparam logic [5:0] CMD_APP       = 6'd55;
   localparam logic [5:0] CMD_READ_OCR  = 6'd58;

   localparam logic [1:0] NEXT_CMD8  = 2'd0;
   localparam logic [1:0] NEXT_CMD55 = 2'd1;
   localparam logic [1:0] NEXT_DONE  = 2'd2;
   localparam logic [1:0] NEXT_LOOP  = 2'd3;

   localparam logic [1:0] CARD_NONE = 2'd0;
   localparam logic [1:0] CARD_V1   = 2'd1;
   localparam logic [1:0] CARD_V2   = 2'd2;
   localparam logic [1:0] CARD_HC   = 2'd3;

   localparam logic [7:0] BYTE_IDLE  = 8'hFF;
   localparam logic [7:0] TOKEN_DATA = 8'hFE;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  request;
      logic [31:0] sector;
      logic [7:0]  sector_count;
      logic [7:0]  card_byte;
      logic [7:0]  write_byte;
   } req_type;

   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       select_n;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       want_write_byte;
      logic       done_res;
      logic [1:0] status;
      logic [1:0] card_kind;
      logic       fast_clock;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [11:0] cmd_timeout;
      logic [11:0] op_timeout;
      logic [11:0] wbusy_timeout;
      logic [7:0]  poll_limit;
      logic [3:0]  settle_delay;
   } csr_type;

endpackage

// ----- sv/sdspi_csr.sv -----
// Configuration register file of the SD card sequencer.
module sdspi_csr
   import sdspi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data,
   output csr_type     csr
);

   csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_CMD_TIMEOUT:   csr_in.cmd_timeout   = csr_data;
            CSR_OP_TIMEOUT:    csr_in.op_timeout    = csr_data;
            CSR_WBUSY_TIMEOUT: csr_in.wbusy_timeout = csr_data;
            CSR_POLL_LIMIT:    csr_in.poll_limit    = csr_data[7:0];
            CSR_SETTLE:        csr_in.settle_delay  = csr_data[3:0];
            default:           csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.cmd_timeout   <= 12'd300;
         csr_ff.op_timeout    <= 12'd3000;
         csr_ff.wbusy_timeout <= 12'd600;
         csr_ff.poll_limit    <= 8'd255;
         csr_ff.settle_delay  <= 4'd1;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

// ----- sv/sd_card_spi_host_sequencer.sv -----
// SD card SPI-mode host sequencer: one event beat in, at most one result beat out.
// Each accepted beat (host request, card byte, write data byte or millisecond
// tick) is handled by the combinational sequencer logic and its result, if any,
// is held in an output register, so a new beat is taken every cycle while the
// result side keeps up; a held result stalls the input only when the output
// register is full and not being drained. There is no clearing pass after reset.
module sd_card_spi_host_sequencer
   import sdspi_pkg::*;
#(
   parameter int DUMMY_CLOCK_BYTES = 10,
   parameter int TIMER_BITS        = 12
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [11:0] csr_data
);

   localparam int SECTOR_BYTES = 512;
   localparam int IDX_BITS = 10;
   localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

   csr_type csr;

   sdspi_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr       (csr)
   );

   phase_type             phase_ff, phase_in;
   logic [1:0]            card_ff, card_in;
   logic                  ready_ff, ready_in;
   logic [TIMER_BITS-1:0] ms_ff, ms_in, loop_ff, loop_in;
   logic [7:0]            poll_ff, poll_in;
   logic [IDX_BITS-1:0]   idx_ff, idx_in;
   logic [31:0]           addr_ff, addr_in;
   logic [7:0]            left_ff, left_in;
   logic [5:0]            cmd_ff, cmd_in;
   logic                  sel_ff, sel_in;
   logic [1:0]            snext_ff, snext_in;
   logic                  wr_ff, wr_in;
   logic [7:0]            rb_ff [4];
   logic                  rb_we;
   logic [1:0]            rb_addr;

   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_ff, out_in;

   logic                  accept;
   logic                  emit;
   logic                  sv, rv, want, done;
   logic [7:0]            sb, rbyte;
   logic [1:0]            st;

   assign req_stall = out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   function automatic logic [7:0] frame_byte(input logic [5:0] cmd, input logic [2:0] i,
                                            input logic [1:0] ct, input logic [31:0] ad);
      logic [31:0] a;
      logic [7:0]  r;
      begin
         case (cmd)
            CMD_IF_COND: a = 32'h0000_01AA;
            CMD_APP_OP:  a = (ct == CARD_V2) ? 32'h4000_0000 : 32'd0;
            CMD_STATUS, CMD_READ, CMD_WRITE: a = ad;
            default:     a = 32'd0;
         endcase
         case (i)
            3'd0: r = 8'h40 | {2'b00, cmd};
            3'd1: r = a[31:24];
            3'd2: r = a[23:16];
            3'd3: r = a[15:8];
            3'd4: r = a[7:0];
            default: begin
               if (cmd == CMD_GO_IDLE) r = 8'h95;
               else if (cmd == CMD_IF_COND) r = 8'h87;
               else r = BYTE_IDLE;
            end
         endcase
         frame_byte = r;
      end
   endfunction

   always_comb begin
      logic [7:0] b;
      logic [TIMER_BITS-1:0] ctmo;
      logic [TIMER_BITS-1:0] otmo;
      logic [TIMER_BITS-1:0] wtmo;
      logic [TIMER_BITS-1:0] sdel;
      logic       resp_go;
      logic [7:0] resp;
      logic       settle_go;
      logic [1:0] settle_nx;
      logic       after_go;
      logic       start_go;
      logic [5:0] start_cmd;
      logic       fin_go;
      logic [1:0] fin_st;
      logic       nblk_go;
      logic       sblk_go;
      logic [7:0] pc1;
      logic [IDX_BITS-1:0] i1;

      phase_in = phase_ff; card_in = card_ff; ready_in = ready_ff;
      ms_in = ms_ff; loop_in = loop_ff; poll_in = poll_ff; idx_in = idx_ff;
      addr_in = addr_ff; left_in = left_ff; cmd_in = cmd_ff; sel_in = sel_ff;
      snext_in = snext_ff; wr_in = wr_ff;
      rb_we = 1'b0; rb_addr = idx_ff[1:0];
      emit = 1'b0; sv = 1'b0; sb = 8'd0; rv = 1'b0; rbyte = 8'd0;
      want = 1'b0; done = 1'b0; st = ST_OK;
      b = req_data.card_byte;
      ctmo = TIMER_BITS'(csr.cmd_timeout);
      otmo = TIMER_BITS'(csr.op_timeout);
      wtmo = TIMER_BITS'(csr.wbusy_timeout);
      sdel = TIMER_BITS'(csr.settle_delay);
      resp_go = 1'b0; resp = b; settle_go = 1'b0; settle_nx = NEXT_CMD8;
      after_go = 1'b0; start_go = 1'b0; start_cmd = CMD_GO_IDLE;
      fin_go = 1'b0; fin_st = ST_OK; nblk_go = 1'b0; sblk_go = 1'b0;
      pc1 = poll_ff + 8'd1;
      i1 = idx_ff + 1'b1;

      if (accept) begin
         case (req_data.kind)
            KIND_CARD: begin
               case (phase_ff)
                  PH_DUMMY: begin
                     idx_in = i1;
                     if (i1 < IDX_BITS'(DUMMY_CLOCK_BYTES)) begin
                        emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
                     end else begin
                        loop_in = '0; start_go = 1'b1; start_cmd = CMD_GO_IDLE;
                     end
                  end
                  PH_CWAIT: begin
                     if (b == BYTE_IDLE) begin
                        idx_in = IDX_BITS'(1); phase_in = PH_CFRAME;
                        emit = 1'b1; sv = 1'b1;
                        sb = frame_byte(cmd_ff, 3'd0, card_ff, addr_ff);
                     end else if (ms_ff >= ctmo) begin
                        sel_in = 1'b1; resp_go = 1'b1; resp = BYTE_IDLE;
                     end else begin
                        emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
                     end
                  end
                  PH_CFRAME: begin
                     emit = 1'b1; sv = 1'b1;
                     if (idx_ff < IDX_BITS'(6)) begin
                        idx_in = i1;
                        sb = frame_byte(cmd_ff, idx_ff[2:0], card_ff, addr_ff);
                     end else begin
                        poll_in = '0; phase_in = PH_CRESP; sb = BYTE_IDLE;
                     end
                  end
                  PH_CRESP: begin
                     if (!b[7]) begin
                        resp_go = 1'b1;
                     end else begin
                        poll_in = pc1;
                        if (pc1 >= csr.poll_limit) resp_go = 1'b1;
                        else begin
                           emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
                        end
                     end
                  end
                  PH_R4: begin
                     rb_we = 1'b1;
                     idx_in = i1;
                     if (i1 < IDX_BITS'(4)) begin
                        emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
                     end else if (cmd_ff == CMD_IF_COND) begin
                        if (rb_ff[2] != 8'h01 || b != 8'hAA) begin
                           card_in = CARD_NONE; ready_in = 1'b0;
                           fin_go = 1'b1; fin_st = ST_NOTREADY;
                        end else begin
                           card_in = CARD_V2; settle_go = 1'b1; settle_nx = NEXT_LOOP;
                        end
                     end else begin
                        if ((rb_ff[0] & 8'hC0) == 8'hC0) card_in = CARD_HC;
                        ready_in = 1'b1; fin_go = 1'b1; fin_st = ST_OK;
                     end
                  end
                  PH_TOKEN: begin
                     if (b != BYTE_IDLE) begin
                        if (b != TOKEN_DATA) begin
                           fin_go = 1'b1; fin_st = ST_ERROR;
                        end else begin
                           idx_in = '0; phase_in = PH_RDATA;
                           emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
                        end
                     end else if (ms_ff >= ctmo) begin
                        fin_go = 1'b1; fin_st = ST_ERROR;
                     end else begin
                        emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
                     end
                  end
                  PH_RDATA: begin
                     idx_in = i1;
                     if (i1 < IDX_BITS'(SECTOR_BYTES + 2)) begin
                        emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
                        if (idx_ff < IDX_BITS'(SECTOR_BYTES)) begin
                           rv = 1'b1; rbyte = b;
                        end
                     end else begin
                        nblk_go = 1'b1;
                     end
                  end
                  PH_WTOKEN: begin
                     idx_in = '0; phase_in = PH_WWANT;
                     emit = 1'b1; want = 1'b1;
                  end
                  PH_WDATA: begin
                     if (idx_ff >= IDX_BITS'(SECTOR_BYTES + 2)) begin
                        if ((b & 8'h1F) != 8'h05) begin
                           fin_go = 1'b1; fin_st = ST_ERROR;
                        end else begin
                           ms_in = '0; phase_in = PH_WBUSY;
                           emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
                        end
                     end else begin
                        idx_in = i1;
                        emit = 1'b1;
                        if (i1 < IDX_BITS'(SECTOR_BYTES)) begin
                           phase_in = PH_WWANT; want = 1'b1;
                        end else begin
                           sv = 1'b1; sb = BYTE_IDLE;
                        end
                     end
                  end
                  PH_WBUSY: begin
                     if (b == BYTE_IDLE) begin
                        start_go = 1'b1; start_cmd = CMD_STATUS;
                     end else if (ms_ff >= wtmo) begin
                        fin_go = 1'b1; fin_st = ST_ERROR;
                     end else begin
                        emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
                     end
                  end
                  PH_STATUS2: begin
                     if (b != 8'd0) begin
                        fin_go = 1'b1; fin_st = ST_ERROR;
                     end else begin
                        nblk_go = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            KIND_WDATA: begin
               if (phase_ff == PH_WWANT) begin
                  phase_in = PH_WDATA;
                  emit = 1'b1; sv = 1'b1; sb = req_data.write_byte;
               end
            end
            KIND_TICK: begin
               if (ms_ff < TIMER_MAX) ms_in = ms_ff + 1'b1;
               if (loop_ff < TIMER_MAX) loop_in = loop_ff + 1'b1;
               if (phase_ff == PH_SETTLE && ms_in >= sdel) after_go = 1'b1;
            end
            default: begin
               if (phase_ff == PH_IDLE) begin
                  case (req_data.request)
                     REQ_INIT: begin
                        ready_in = 1'b0; card_in = CARD_NONE; sel_in = 1'b1;
                        idx_in = '0; phase_in = PH_DUMMY;
                        emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
                     end
                     REQ_BAD: begin
                        fin_go = 1'b1; fin_st = ST_ERROR;
                     end
                     default: begin
                        if (!ready_ff) begin
                           fin_go = 1'b1; fin_st = ST_NOTREADY;
                        end else begin
                           wr_in = (req_data.request == REQ_WRITE);
                           left_in = req_data.sector_count;
                           addr_in = (card_ff == CARD_HC) ? req_data.sector
                                                          : {req_data.sector[22:0], 9'd0};
                           sblk_go = 1'b1;
                        end
                     end
                  endcase
               end
            end
         endcase

         if (resp_go) begin
            case (cmd_ff)
               CMD_GO_IDLE: begin
                  if (resp == 8'h01) begin
                     settle_go = 1'b1; settle_nx = NEXT_CMD8;
                  end else if (loop_ff > ctmo) begin
                     card_in = CARD_NONE; ready_in = 1'b0;
                     fin_go = 1'b1; fin_st = ST_NOCARD;
                  end else begin
                     start_go = 1'b1; start_cmd = CMD_GO_IDLE;
                  end
               end
               CMD_IF_COND: begin
                  if (resp == 8'h01) begin
                     idx_in = '0; phase_in = PH_R4;
                     emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
                  end else begin
                     card_in = CARD_V1; settle_go = 1'b1; settle_nx = NEXT_LOOP;
                  end
               end
               CMD_APP: begin
                  start_go = 1'b1; start_cmd = CMD_APP_OP;
               end
               CMD_APP_OP: begin
                  if (resp == 8'h00) begin
                     settle_go = 1'b1; settle_nx = NEXT_DONE;
                  end else if (loop_ff > otmo) begin
                     card_in = CARD_NONE; ready_in = 1'b0;
                     fin_go = 1'b1; fin_st = ST_NOTREADY;
                  end else begin
                     settle_go = 1'b1; settle_nx = NEXT_CMD55;
                  end
               end
               CMD_READ_OCR: begin
                  if (resp != 8'h00) begin
                     card_in = CARD_NONE; ready_in = 1'b0;
                     fin_go = 1'b1; fin_st = ST_NOTREADY;
                  end else begin
                     idx_in = '0; phase_in = PH_R4;
                     emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
                  end
               end
               CMD_READ: begin
                  if (resp != 8'h00) begin
                     fin_go = 1'b1; fin_st = ST_ERROR;
                  end else begin
                     ms_in = '0; phase_in = PH_TOKEN;
                     emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
                  end
               end
               CMD_WRITE: begin
                  if (resp != 8'h00) begin
                     fin_go = 1'b1; fin_st = ST_ERROR;
                  end else begin
                     phase_in = PH_WTOKEN;
                     emit = 1'b1; sv = 1'b1; sb = TOKEN_DATA;
                  end
               end
               CMD_STATUS: begin
                  if (resp != 8'h00) begin
                     fin_go = 1'b1; fin_st = ST_ERROR;
                  end else begin
                     phase_in = PH_STATUS2;
                     emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
                  end
               end
               default: begin
                  fin_go = 1'b1; fin_st = ST_ERROR;
               end
            endcase
         end

         if (settle_go) begin
            snext_in = settle_nx; sel_in = 1'b1; ms_in = '0;
            if (csr.settle_delay == 4'd0) after_go = 1'b1;
            else begin
               phase_in = PH_SETTLE; emit = 1'b1;
            end
         end

         if (after_go) begin
            case (settle_go ? settle_nx : snext_ff)
               NEXT_CMD8: begin
                  start_go = 1'b1; start_cmd = CMD_IF_COND;
               end
               NEXT_LOOP: begin
                  loop_in = '0; start_go = 1'b1; start_cmd = CMD_APP;
               end
               NEXT_CMD55: begin
                  start_go = 1'b1; start_cmd = CMD_APP;
               end
               default: begin
                  if (card_in == CARD_V2) begin
                     start_go = 1'b1; start_cmd = CMD_READ_OCR;
                  end else begin
                     ready_in = 1'b1; fin_go = 1'b1; fin_st = ST_OK;
                  end
               end
            endcase
         end

         if (nblk_go) begin
            sel_in = 1'b1;
            left_in = left_ff - 8'd1;
            addr_in = addr_ff + ((card_ff == CARD_HC) ? 32'd1 : 32'(SECTOR_BYTES));
            sblk_go = 1'b1;
         end

         if (sblk_go) begin
            if (left_in == 8'd0) begin
               fin_go = 1'b1; fin_st = ST_OK;
            end else begin
               start_go = 1'b1; start_cmd = wr_in ? CMD_WRITE : CMD_READ;
            end
         end

         if (start_go) begin
            cmd_in = start_cmd; sel_in = 1'b0; ms_in = '0; phase_in = PH_CWAIT;
            emit = 1'b1; sv = 1'b1; sb = BYTE_IDLE;
         end

         if (fin_go) begin
            sel_in = 1'b1; phase_in = PH_IDLE;
            emit = 1'b1; done = 1'b1; st = fin_st;
         end
      end

      out_valid_in = out_valid_ff && rsp_stall;
      out_in = out_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_in.send_valid = sv;
         out_in.send_byte = sb;
         out_in.select_n = sel_in;
         out_in.read_valid = rv;
         out_in.read_byte = rbyte;
         out_in.want_write_byte = want;
         out_in.done_res = done;
         out_in.status = st;
         out_in.card_kind = card_in;
         out_in.fast_clock = ready_in;
         out_in.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; card_ff <= CARD_NONE; ready_ff <= 1'b0;
         ms_ff <= '0; loop_ff <= '0; poll_ff <= '0; idx_ff <= '0;
         addr_ff <= '0; left_ff <= '0; cmd_ff <= '0; sel_ff <= 1'b1;
         snext_ff <= NEXT_CMD8; wr_ff <= 1'b0; out_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in; card_ff <= card_in; ready_ff <= ready_in;
         ms_ff <= ms_in; loop_ff <= loop_in; poll_ff <= poll_in; idx_ff <= idx_in;
         addr_ff <= addr_in; left_ff <= left_in; cmd_ff <= cmd_in; sel_ff <= sel_in;
         snext_ff <= snext_in; wr_ff <= wr_in; out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (rb_we) rb_ff[rb_addr] <= req_data.card_byte;
   end

endmodule
